FILE: rtl/polygon_edge_rect_clipper_defines.svh
// Assertion macros for the polygon edge clipper.
// Included by every RTL file that carries concurrent assertions.
`ifndef POLYGON_EDGE_RECT_CLIPPER_DEFINES_SVH
`define POLYGON_EDGE_RECT_CLIPPER_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked property, switched off while reset is asserted.
`define PERC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed");
// Checked property that also holds during reset.
`define PERC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PERC_ASSERT(name, clk, rstn, prop)
`define PERC_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

FILE: rtl/perc_pkg.sv
// Shared constants for the polygon edge clipper.
// No dependencies; used by perc_isect and polygon_edge_rect_clipper.
package perc_pkg;

  // Coordinate width in bits (signed fixed point, 8 fraction bits by default).
  localparam int CoordBits = 32;

  // Configuration register indexes.
  localparam int CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] RegLeft   = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegTop    = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegRight  = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegBottom = 2'd3;

  // Point kind codes.
  localparam logic KindMove = 1'b0;
  localparam logic KindLine = 1'b1;

endpackage

FILE: rtl/polygon_edge_rect_clipper.sv
// Polygon edge clipper against a rectangle, top level with its sequencer.
// Depends on perc_pkg and perc_isect.
//
// A line item runs from the current point to the new point and yields zero to
// three clipped segments; a move or an edge with a null end yields none. One
// item is taken at a time: in_stall_o stays high until the last segment has
// been placed in the output register. Each crossing goes through the single
// shared intersection unit, which at 32 bits runs a 33-step multiply, a
// 66-step divide and a final add and saturate; an edge needs up to four
// crossings.
`include "polygon_edge_rect_clipper_defines.svh"
module polygon_edge_rect_clipper import perc_pkg::*; #(
  parameter int CoordW = CoordBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Point items
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     kind_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic                     point_null_i,
  // Segment items
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CoordW-1:0] seg_start_x_o,
  output logic signed [CoordW-1:0] seg_start_y_o,
  output logic signed [CoordW-1:0] seg_end_x_o,
  output logic signed [CoordW-1:0] seg_end_y_o,
  output logic                     seg_last_o,
  // Configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxBits-1:0]    cfg_index_i,
  input  logic [CoordW-1:0]        cfg_data_i
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StY1    = 4'd1;
  localparam logic [3:0] StY1B   = 4'd2;
  localparam logic [3:0] StY2    = 4'd3;
  localparam logic [3:0] StY2B   = 4'd4;
  localparam logic [3:0] StX     = 4'd5;
  localparam logic [3:0] StA1    = 4'd6;
  localparam logic [3:0] StA2    = 4'd7;
  localparam logic [3:0] StA3    = 4'd8;
  localparam logic [3:0] StA4    = 4'd9;
  localparam logic [3:0] StA5    = 4'd10;
  localparam logic [3:0] StB1    = 4'd11;
  localparam logic [3:0] StB2    = 4'd12;
  localparam logic [3:0] StIsect = 4'd13;
  localparam logic [3:0] StEmit  = 4'd14;

  typedef logic signed [CoordW-1:0] coord_t;

  logic [3:0] state_q, state_d, ret_q, ret_d;
  coord_t left_q, top_q, right_q, bottom_q;
  coord_t cur_x_q, cur_y_q;
  logic   cur_null_q;
  coord_t x1_q, y1_q, x2_q, y2_q, x1_d, y1_d, x2_d, y2_d;
  coord_t e_q, e_d, near_q, near_d, far_q, far_d, ya_q, ya_d, yb_q, yb_d;
  logic   across_q, across_d;
  coord_t psx_q, psy_q, pex_q, pey_q, psx_d, psy_d, pex_d, pey_d;
  logic   plast_q, plast_d;
  logic   out_valid_q, out_valid_d;
  coord_t osx_q, osy_q, oex_q, oey_q;
  logic   olast_q;
  logic   load_out;

  logic   iu_start, iu_done;
  coord_t iu_a1, iu_b1, iu_a2, iu_b2, iu_e, iu_res;

  logic in_acc;
  logic x1_lo, x1_hi, x2_lo, x2_hi;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign x1_lo = x1_q < left_q;
  assign x1_hi = x1_q > right_q;
  assign x2_lo = x2_q < left_q;
  assign x2_hi = x2_q > right_q;
  assign load_out = (state_q == StEmit) && (!out_valid_q || !out_stall_i);

  perc_isect #(.CoordW(CoordW)) u_isect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (iu_start),
    .a1_i    (iu_a1),
    .b1_i    (iu_b1),
    .a2_i    (iu_a2),
    .b2_i    (iu_b2),
    .e_i     (iu_e),
    .done_o  (iu_done),
    .res_o   (iu_res)
  );

  // Edge sequencer: clip in y, then in x, queueing segments one at a time.
  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    x1_d = x1_q; y1_d = y1_q; x2_d = x2_q; y2_d = y2_q;
    e_d = e_q; near_d = near_q; far_d = far_q; ya_d = ya_q; yb_d = yb_q;
    across_d = across_q;
    psx_d = psx_q; psy_d = psy_q; pex_d = pex_q; pey_d = pey_q; plast_d = plast_q;
    iu_start = 1'b0;
    iu_a1 = x1_q; iu_b1 = y1_q; iu_a2 = x2_q; iu_b2 = y2_q; iu_e = e_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && kind_i == KindLine && !cur_null_q && !point_null_i) begin
          x1_d = cur_x_q; y1_d = cur_y_q; x2_d = point_x_i; y2_d = point_y_i;
          state_d = StY1;
        end
      end
      StY1: begin
        if (y1_q < top_q) begin
          if (y2_q < top_q) begin
            state_d = StIdle;
          end else begin
            iu_start = 1'b1; iu_e = top_q; e_d = top_q;
            ret_d = StY1B; state_d = StIsect;
          end
        end else if (y1_q > bottom_q) begin
          if (y2_q > bottom_q) begin
            state_d = StIdle;
          end else begin
            iu_start = 1'b1; iu_e = bottom_q; e_d = bottom_q;
            ret_d = StY1B; state_d = StIsect;
          end
        end else begin
          state_d = StY2;
        end
      end
      StY1B: begin
        x1_d = iu_res; y1_d = e_q; state_d = StY2;
      end
      StY2: begin
        if (y2_q < top_q) begin
          iu_start = 1'b1; iu_e = top_q; e_d = top_q;
          ret_d = StY2B; state_d = StIsect;
        end else if (y2_q > bottom_q) begin
          iu_start = 1'b1; iu_e = bottom_q; e_d = bottom_q;
          ret_d = StY2B; state_d = StIsect;
        end else begin
          state_d = StX;
        end
      end
      StY2B: begin
        x2_d = iu_res; y2_d = e_q; state_d = StX;
      end
      StX: begin
        iu_a1 = y1_q; iu_b1 = x1_q; iu_a2 = y2_q; iu_b2 = x2_q;
        if (x1_lo || x1_hi) begin
          near_d = x1_lo ? left_q : right_q;
          far_d = x1_lo ? right_q : left_q;
          across_d = x1_lo ? x2_hi : x2_lo;
          if (x1_lo ? x2_lo : x2_hi) begin
            psx_d = near_d; psy_d = y1_q; pex_d = near_d; pey_d = y2_q; plast_d = 1'b1;
            ret_d = StIdle; state_d = StEmit;
          end else begin
            iu_start = 1'b1; iu_e = near_d;
            ret_d = StA1; state_d = StIsect;
          end
        end else if (x2_lo || x2_hi) begin
          near_d = x2_lo ? left_q : right_q;
          iu_start = 1'b1; iu_e = near_d;
          ret_d = StB1; state_d = StIsect;
        end else begin
          psx_d = x1_q; psy_d = y1_q; pex_d = x2_q; pey_d = y2_q; plast_d = 1'b1;
          ret_d = StIdle; state_d = StEmit;
        end
      end
      StA1: begin
        ya_d = iu_res;
        psx_d = near_q; psy_d = y1_q; pex_d = near_q; pey_d = iu_res; plast_d = 1'b0;
        ret_d = across_q ? StA2 : StA3; state_d = StEmit;
      end
      StA2: begin
        iu_a1 = y1_q; iu_b1 = x1_q; iu_a2 = y2_q; iu_b2 = x2_q; iu_e = far_q;
        iu_start = 1'b1;
        ret_d = StA4; state_d = StIsect;
      end
      StA3: begin
        psx_d = near_q; psy_d = ya_q; pex_d = x2_q; pey_d = y2_q; plast_d = 1'b1;
        ret_d = StIdle; state_d = StEmit;
      end
      StA4: begin
        yb_d = iu_res;
        psx_d = near_q; psy_d = ya_q; pex_d = far_q; pey_d = iu_res; plast_d = 1'b0;
        ret_d = StA5; state_d = StEmit;
      end
      StA5: begin
        psx_d = far_q; psy_d = yb_q; pex_d = far_q; pey_d = y2_q; plast_d = 1'b1;
        ret_d = StIdle; state_d = StEmit;
      end
      StB1: begin
        ya_d = iu_res;
        psx_d = x1_q; psy_d = y1_q; pex_d = near_q; pey_d = iu_res; plast_d = 1'b0;
        ret_d = StB2; state_d = StEmit;
      end
      StB2: begin
        psx_d = near_q; psy_d = ya_q; pex_d = near_q; pey_d = y2_q; plast_d = 1'b1;
        ret_d = StIdle; state_d = StEmit;
      end
      StIsect: begin
        if (iu_done) begin
          state_d = ret_q;
        end
      end
      StEmit: begin
        if (load_out) begin
          state_d = ret_q;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output register: filled from the pending segment, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ret_q       <= StIdle;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      top_q       <= '0;
      right_q     <= '0;
      bottom_q    <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_null_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          RegLeft:   left_q   <= cfg_data_i;
          RegTop:    top_q    <= cfg_data_i;
          RegRight:  right_q  <= cfg_data_i;
          RegBottom: bottom_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        cur_x_q    <= point_x_i;
        cur_y_q    <= point_y_i;
        cur_null_q <= point_null_i;
      end
    end
  end

  // Working coordinates and the pending segment.
  always_ff @(posedge clk_i) begin
    x1_q <= x1_d; y1_q <= y1_d; x2_q <= x2_d; y2_q <= y2_d;
    e_q <= e_d; near_q <= near_d; far_q <= far_d; ya_q <= ya_d; yb_q <= yb_d;
    across_q <= across_d;
    psx_q <= psx_d; psy_q <= psy_d; pex_q <= pex_d; pey_q <= pey_d; plast_q <= plast_d;
    if (load_out) begin
      osx_q <= psx_q; osy_q <= psy_q; oex_q <= pex_q; oey_q <= pey_q;
      olast_q <= plast_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign seg_start_x_o = osx_q;
  assign seg_start_y_o = osy_q;
  assign seg_end_x_o   = oex_q;
  assign seg_end_y_o   = oey_q;
  assign seg_last_o    = olast_q;

  // The unit reports completion only while the sequencer waits for it.
  `PERC_ASSERT(a_done_in_wait, clk_i, rst_ni, iu_done |-> state_q == StIsect)
  // A segment leaving the sequencer lands in the output register.
  `PERC_ASSERT(a_emit_loads, clk_i, rst_ni, load_out |=> out_valid_q)
  // A drawable line item starts the y clipping step.
  `PERC_ASSERT(a_line_starts, clk_i, rst_ni,
    (in_acc && kind_i == KindLine && !cur_null_q && !point_null_i) |=> state_q == StY1)
  // The sequencer only starts the unit while it is free.
  `PERC_ASSERT(a_no_restart, clk_i, rst_ni, iu_start |=> !iu_start)

endmodule

FILE: rtl/perc_isect.sv
// Iterative intersection unit: a1 + (a2 - a1) * (e - b1) / (b2 - b1).
// Shift-add multiply, then restoring divide, one bit per cycle. Uses perc_pkg.
`include "polygon_edge_rect_clipper_defines.svh"
module perc_isect import perc_pkg::*; #(
  parameter int CoordW = CoordBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [CoordW-1:0] a1_i,
  input  logic signed [CoordW-1:0] b1_i,
  input  logic signed [CoordW-1:0] a2_i,
  input  logic signed [CoordW-1:0] b2_i,
  input  logic signed [CoordW-1:0] e_i,
  output logic                     done_o,
  output logic signed [CoordW-1:0] res_o
);

  localparam int DW = CoordW + 1;      // difference width
  localparam int PW = 2 * DW;          // product and quotient width
  localparam int RW = CoordW + 2;      // remainder width
  localparam int NW = $clog2(PW + 1);  // step counter width
  localparam int SW = PW + 2;          // final sum width

  localparam logic [1:0] UIdle = 2'd0;
  localparam logic [1:0] UMul  = 2'd1;
  localparam logic [1:0] UDiv  = 2'd2;
  localparam logic [1:0] UFin  = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [NW-1:0]           cnt_q, cnt_d;
  logic [PW-1:0]           prod_q, prod_d;
  logic [DW-1:0]           mcand_q, mcand_d;
  logic [DW-1:0]           div_q, div_d;
  logic [RW-1:0]           rem_q, rem_d;
  logic signed [CoordW-1:0] a1_q, a1_d;
  logic                    neg_q, neg_d;
  logic                    zero_q, zero_d;
  logic signed [CoordW-1:0] res_q, res_d;
  logic                    done_q, done_d;

  logic signed [DW-1:0] da, de, db;
  logic [DW:0]          msum;
  logic [RW-1:0]        shifted;
  logic                 take;
  logic signed [SW-1:0] sum;
  logic                 ovf;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  always_comb begin
    da = DW'(a2_i) - DW'(a1_i);
    de = DW'(e_i) - DW'(b1_i);
    db = DW'(b2_i) - DW'(b1_i);
    msum = {1'b0, prod_q[PW-1:DW]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
    shifted = {rem_q[RW-2:0], prod_q[PW-1]};
    take = shifted >= {1'b0, div_q};
    if (neg_q) begin
      sum = SW'(a1_q) - $signed({2'b00, prod_q});
    end else begin
      sum = SW'(a1_q) + $signed({2'b00, prod_q});
    end
    ovf = !((&sum[SW-1:CoordW-1]) || !(|sum[SW-1:CoordW-1]));
  end

  // Sequencer: multiply, divide, then add and saturate.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    mcand_d = mcand_q;
    div_d   = div_q;
    rem_d   = rem_q;
    a1_d    = a1_q;
    neg_d   = neg_q;
    zero_d  = zero_q;
    res_d   = res_q;
    done_d  = 1'b0;
    unique case (state_q)
      UIdle: begin
        if (start_i) begin
          a1_d    = a1_i;
          neg_d   = (da[DW-1] ^ de[DW-1]) ^ db[DW-1];
          zero_d  = (db == '0);
          mcand_d = mag(da);
          div_d   = mag(db);
          prod_d  = {{DW{1'b0}}, mag(de)};
          cnt_d   = '0;
          state_d = (db == '0) ? UFin : UMul;
        end
      end
      UMul: begin
        prod_d = {msum, prod_q[DW-1:1]};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == NW'(DW - 1)) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = UDiv;
        end
      end
      UDiv: begin
        rem_d  = take ? (shifted - {1'b0, div_q}) : shifted;
        prod_d = {prod_q[PW-2:0], take};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == NW'(PW - 1)) begin
          state_d = UFin;
        end
      end
      UFin: begin
        if (zero_q) begin
          res_d = a1_q;
        end else if (ovf) begin
          res_d = sum[SW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
        end else begin
          res_d = sum[CoordW-1:0];
        end
        done_d  = 1'b1;
        state_d = UIdle;
      end
      default: state_d = UIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= UIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    mcand_q <= mcand_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    a1_q    <= a1_d;
    neg_q   <= neg_d;
    zero_q  <= zero_d;
    res_q   <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // A new operation only starts on an idle unit.
  `PERC_ASSERT(a_start_idle, clk_i, rst_ni, start_i |-> state_q == UIdle)
  // Completion is a single-cycle pulse.
  `PERC_ASSERT(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o)
  // Completion follows the final step.
  `PERC_ASSERT(a_done_after_fin, clk_i, rst_ni, done_o |-> $past(state_q) == UFin)

endmodule

FILE: tb/polygon_edge_rect_clipper_tb.sv
// Self-checking testbench for polygon_edge_rect_clipper: clipped segments are predicted
// per accepted point and compared field by field. Depends on perc_pkg and the RTL top.
`timescale 1ns / 100ps
module polygon_edge_rect_clipper_tb;
  import perc_pkg::*;

  localparam longint CoordMax = 64'sd2147483647;
  localparam longint CoordMin = -64'sd2147483648;
  localparam int unsigned CycleLimit = 1500000;
  localparam int DrainCycles = 500;

  typedef struct {
    logic signed [CoordBits-1:0] sx, sy, ex, ey;
    logic last;
  } seg_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = KindMove;
  logic signed [CoordBits-1:0] point_x_i = '0;
  logic signed [CoordBits-1:0] point_y_i = '0;
  logic point_null_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [CoordBits-1:0] seg_start_x_o, seg_start_y_o, seg_end_x_o, seg_end_y_o;
  logic seg_last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i = RegLeft;
  logic [CoordBits-1:0] cfg_data_i = '0;

  polygon_edge_rect_clipper i_dut (.*);

  // Clock and cycle budget.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int unsigned cycle_cnt = 0;
  int err_cnt = 0;
  int point_cnt = 0;
  int seg_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Clipper state as the block should hold it.
  longint rect_l, rect_t, rect_r, rect_b;
  longint cur_x, cur_y;
  logic cur_null;
  seg_t seg_q[$];

  function automatic longint crossing(longint a1, longint b1, longint a2, longint b2,
                                      longint e);
    longint da, de, db, q, r;
    logic [127:0] ma, me, md, quo;
    logic neg;
    da = a2 - a1;
    de = e - b1;
    db = b2 - b1;
    if (db == 0) return a1;
    neg = ((da < 0) != (de < 0)) != (db < 0);
    ma = (da < 0) ? -da : da;
    me = (de < 0) ? -de : de;
    md = (db < 0) ? -db : db;
    quo = (ma * me) / md;
    // The quotient is capped at 2**62 before the sum is saturated.
    q = (quo >= (128'd1 << 62)) ? (64'sd1 <<< 62) : longint'(quo[63:0]);
    r = neg ? a1 - q : a1 + q;
    if (r > CoordMax) r = CoordMax;
    if (r < CoordMin) r = CoordMin;
    return r;
  endfunction

  function automatic void push_seg(longint sx, longint sy, longint ex, longint ey);
    seg_t s;
    s.sx = sx[CoordBits-1:0];
    s.sy = sy[CoordBits-1:0];
    s.ex = ex[CoordBits-1:0];
    s.ey = ey[CoordBits-1:0];
    s.last = 1'b0;
    seg_q.push_back(s);
  endfunction

  function automatic void predict_edge(longint x1, longint y1, longint x2, longint y2);
    longint yn, yf, near_b, far_b, side;
    logic same_side, across;
    // Clip in y first; an edge wholly above or below is dropped.
    if (y1 < rect_t) begin
      if (y2 < rect_t) return;
      x1 = crossing(x1, y1, x2, y2, rect_t);
      y1 = rect_t;
    end else if (y1 > rect_b) begin
      if (y2 > rect_b) return;
      x1 = crossing(x1, y1, x2, y2, rect_b);
      y1 = rect_b;
    end
    if (y2 < rect_t) begin
      x2 = crossing(x1, y1, x2, y2, rect_t);
      y2 = rect_t;
    end else if (y2 > rect_b) begin
      x2 = crossing(x1, y1, x2, y2, rect_b);
      y2 = rect_b;
    end
    // Parts outside left or right collapse onto the boundary.
    if (x1 < rect_l || x1 > rect_r) begin
      near_b = (x1 < rect_l) ? rect_l : rect_r;
      far_b = (x1 < rect_l) ? rect_r : rect_l;
      same_side = (x1 < rect_l) ? (x2 < rect_l) : (x2 > rect_r);
      across = (x1 < rect_l) ? (x2 > rect_r) : (x2 < rect_l);
      if (same_side) begin
        push_seg(near_b, y1, near_b, y2);
      end else begin
        yn = crossing(y1, x1, y2, x2, near_b);
        push_seg(near_b, y1, near_b, yn);
        if (across) begin
          yf = crossing(y1, x1, y2, x2, far_b);
          push_seg(near_b, yn, far_b, yf);
          push_seg(far_b, yf, far_b, y2);
        end else begin
          push_seg(near_b, yn, x2, y2);
        end
      end
    end else if (x2 < rect_l || x2 > rect_r) begin
      side = (x2 < rect_l) ? rect_l : rect_r;
      yn = crossing(y1, x1, y2, x2, side);
      push_seg(x1, y1, side, yn);
      push_seg(side, yn, side, y2);
    end else begin
      push_seg(x1, y1, x2, y2);
    end
    seg_q[seg_q.size()-1].last = 1'b1;
  endfunction

  task automatic check_field(string name, logic [CoordBits-1:0] exp_v,
                             logic [CoordBits-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      err_cnt++;
    end
  endtask

  // Prediction on accepted points and config writes; checking of accepted segments.
  always @(posedge clk_i or negedge rst_ni) begin
    seg_t s;
    if (!rst_ni) begin
      rect_l = 0; rect_t = 0; rect_r = 0; rect_b = 0;
      cur_x = 0; cur_y = 0; cur_null = 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegLeft:   rect_l = longint'($signed(cfg_data_i));
          RegTop:    rect_t = longint'($signed(cfg_data_i));
          RegRight:  rect_r = longint'($signed(cfg_data_i));
          RegBottom: rect_b = longint'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        point_cnt++;
        if (kind_i == KindLine && !cur_null && !point_null_i)
          predict_edge(cur_x, cur_y, longint'(point_x_i), longint'(point_y_i));
        cur_x = longint'(point_x_i);
        cur_y = longint'(point_y_i);
        cur_null = point_null_i;
      end
      if (out_valid_o && !out_stall_i) begin
        seg_cnt++;
        if (seg_q.size() == 0) begin
          $error("segment with no expectation pending");
          err_cnt++;
        end else begin
          s = seg_q.pop_front();
          check_field("seg_start_x", s.sx, seg_start_x_o);
          check_field("seg_start_y", s.sy, seg_start_y_o);
          check_field("seg_end_x", s.ex, seg_end_x_o);
          check_field("seg_end_y", s.ey, seg_end_y_o);
          check_field("seg_last", 32'(s.last), 32'(seg_last_o));
        end
      end
    end
  end

  // Receiver: random stall, plus a long hold-off counted down here.
  int stall_pct = 0;
  int hold_cycles = 0;
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Sender: one point item, with random idle cycles in front of it.
  int idle_pct = 0;
  task automatic send_point(logic kind, longint x, longint y, logic is_null);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    point_x_i <= x[CoordBits-1:0];
    point_y_i <= y[CoordBits-1:0];
    point_null_i <= is_null;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Register writes happen only once the block has drained.
  task automatic set_rect(longint l, longint t, longint r, longint b);
    longint vals[4];
    vals = '{l, t, r, b};
    release_input();
    wait (seg_q.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
    foreach (vals[i]) begin
      @(negedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= i[CfgIdxBits-1:0];
      cfg_data_i <= vals[i][CoordBits-1:0];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic longint rand_coord();
    longint span;
    span = (rect_r - rect_l) + (rect_b - rect_t);
    if (span < 0) span = -span;
    span = span / 2 + 64;
    if (span > (64'sd1 << 30) - 1) span = (64'sd1 << 30) - 1;
    case ($urandom_range(9))
      0: return longint'($signed($urandom()));
      1: return $urandom_range(1) ? CoordMax : CoordMin;
      default: begin
        rand_coord = (rect_l + rect_r) / 2 - 2 * span + longint'($urandom_range(32'(4 * span)));
        if (rand_coord > CoordMax) rand_coord = CoordMax;
        if (rand_coord < CoordMin) rand_coord = CoordMin;
      end
    endcase
  endfunction

  // A path: a move then lines, with the odd null point or stray move.
  task automatic send_path();
    int len;
    logic kind;
    len = $urandom_range(8, 2);
    send_point(KindMove, rand_coord(), rand_coord(), 1'b0);
    for (int i = 0; i < len; i++) begin
      kind = ($urandom_range(19) == 0) ? KindMove : KindLine;
      send_point(kind, rand_coord(), rand_coord(), $urandom_range(19) == 0);
    end
  endtask

  task automatic test_directed_edges();
    longint s;
    s = 100 * 256;
    set_rect(0, 0, s, s);
    send_point(KindMove, 10, 10, 1'b0);
    send_point(KindLine, 90, 80, 1'b0);            // inside
    send_point(KindLine, 50, -500, 1'b0);          // leaves through the top
    send_point(KindLine, 60, s + 900, 1'b0);       // crosses the whole height
    send_point(KindMove, 20, -5, 1'b0);
    send_point(KindLine, 30, -90, 1'b0);           // wholly above
    send_point(KindMove, 20, s + 5, 1'b0);
    send_point(KindLine, 30, s + 90, 1'b0);        // wholly below
    send_point(KindMove, -300, 10, 1'b0);
    send_point(KindLine, -20, 60, 1'b0);           // left, same side
    send_point(KindLine, s + 700, 90, 1'b0);       // left across to right
    send_point(KindLine, -800, 20, 1'b0);          // right across to left
    send_point(KindMove, s + 40, 30, 1'b0);
    send_point(KindLine, 50, 70, 1'b0);            // right into the inside
    send_point(KindLine, -60, 40, 1'b0);           // inside out to the left
    send_point(KindLine, 50, 40, 1'b1);            // null end
    send_point(KindLine, 60, 60, 1'b0);            // null start
    send_point(KindMove, CoordMin, CoordMin, 1'b0);
    send_point(KindLine, CoordMax, CoordMax, 1'b0); // full-range diagonal
    send_point(KindLine, CoordMin, CoordMax, 1'b0);
    send_point(KindLine, CoordMax, CoordMin, 1'b0);
    send_point(KindMove, 5, 5, 1'b1);
    send_point(KindLine, 6, 6, 1'b0);
  endtask

  // Inverted rectangle: a horizontal run at the top gives a zero divisor.
  task automatic test_inverted_rect();
    set_rect(200, 100, 0, 0);
    send_point(KindMove, 0, 50, 1'b0);
    send_point(KindLine, 10, 100, 1'b0);
    send_point(KindLine, 300, -40, 1'b0);
    send_point(KindLine, -80, 150, 1'b0);
    for (int i = 0; i < 6; i++) send_path();
  endtask

  task automatic test_random_phases();
    int pcts[4][2];
    longint a, b;
    pcts = '{'{0, 0}, '{71, 0}, '{0, 71}, '{36, 36}};
    foreach (pcts[p]) begin
      idle_pct = pcts[p][0];
      stall_pct = pcts[p][1];
      case (p)
        0: set_rect(-5000, -3000, 7000, 4000);
        1: set_rect(CoordMin, CoordMin, CoordMax, CoordMax);
        2: begin
          a = longint'($signed($urandom()));
          b = longint'($signed($urandom()));
          set_rect(a < b ? a : b, -(64'sd1 << 20), a < b ? b : a, 64'sd1 << 20);
        end
        default: set_rect(CoordMax, 0, CoordMin, -1);
      endcase
      for (int i = 0; i < 18; i++) send_path();
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  // Receiver holds off long enough that the block backs up into its input.
  task automatic test_backpressure();
    set_rect(-256, -256, 256, 256);
    hold_cycles = 3000;
    send_point(KindMove, -1000, -900, 1'b0);
    for (int i = 0; i < 12; i++)
      send_point(KindLine, $urandom_range(1) ? 1000 : -1000, $urandom_range(1) ? 900 : -900,
                 1'b0);
    send_path();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_edges();
    test_inverted_rect();
    test_backpressure();
    test_random_phases();
    release_input();
    wait (seg_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (seg_q.size() != 0) begin
      $error("%0d segments never arrived", seg_q.size());
      err_cnt++;
    end
    $display("Covered %0d points and %0d segments over normal, full-range and inverted",
             point_cnt, seg_cnt);
    $display("rectangles, with sender gaps, receiver stalls and a long output hold-off.");
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/perc_pkg.sv
rtl/perc_isect.sv
rtl/polygon_edge_rect_clipper.sv
tb/polygon_edge_rect_clipper_tb.sv
